/* rtl/mipr_pkg.sv */
// Shared constants, payload types and the binomial table of the multi-index rank core.
`timescale 1ns / 1ps
package mipr_pkg;

	localparam int MAX_VARS   = 8;
	localparam int MAX_ORDER  = 7;
	localparam int EXP_BITS   = 4;
	localparam int EXP_VEC_W  = 32;
	localparam int FUNC_W     = 6;
	localparam int NV_W       = 4;
	localparam int NF_W       = 7;
	localparam int IDX_W      = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	// A difference degree that is still ranked fits in ORD_W bits.
	localparam int ORD_W      = 3;
	// Full degree: up to MAX_VARS * 15.
	localparam int DEG_W      = 7;
	localparam int BIN_W      = 13;
	localparam int PAS_N      = 16;
	localparam int PAS_W      = 4;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_VARS  = 1'b0,
		CFG_NUM_FUNCS = 1'b1
	} cfg_reg_t;

	typedef logic [EXP_BITS-1:0] exp_t;

	typedef struct packed {
		logic                          zero;
		logic [NV_W-1:0]               nv;
		logic [FUNC_W-1:0]             func;
		exp_t [MAX_VARS-1:0]           q;
	} diff_t;

	typedef struct packed {
		logic                          zero;
		logic                          too_high;
		logic [NV_W-1:0]               nv;
		logic [FUNC_W-1:0]             func;
		logic [ORD_W-1:0]              deg;
		logic [MAX_VARS-1:0][ORD_W-1:0] suf;
	} sums_t;

	typedef struct packed {
		logic                          zero;
		logic                          too_high;
		logic [FUNC_W-1:0]             func;
		logic [BIN_W-1:0]              cnt;
		logic [BIN_W-1:0]              pre;
		logic [BIN_W-1:0]              rank;
	} rank_t;

	typedef struct packed {
		logic                          zero;
		logic                          too_high;
		logic [IDX_W-1:0]              p_funcs;
		logic [IDX_W-1:0]              p_func;
		logic [BIN_W-1:0]              rank;
	} prod_t;

	typedef struct packed {
		logic                          entry_is_zero;
		logic [IDX_W-1:0]              source_index;
		logic                          degree_too_high;
	} result_t;

	typedef logic [PAS_N-1:0][PAS_N-1:0][BIN_W-1:0] pascal_t;

	// Pascal's triangle built by additions: entry [a][b] is C(a,b).
	function automatic pascal_t gen_pascal();
		pascal_t p;
		int a;
		int b;
		p = '0;
		for (a = 0; a < PAS_N; a++) begin
			p[a][0] = BIN_W'(1);
			for (b = 1; b <= a; b++) begin
				p[a][b] = p[a-1][b] + p[a-1][b-1];
			end
		end
		return p;
	endfunction

	localparam pascal_t PASCAL = gen_pascal();

endpackage

/* rtl/mipr_diff.sv */
// Stages 1 and 2: exponent differences, zero test, suffix sums and degree.
`timescale 1ns / 1ps
module mipr_diff (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mipr_pkg::EXP_VEC_W-1:0] mon,
	input  logic [mipr_pkg::EXP_VEC_W-1:0] dif,
	input  logic [mipr_pkg::FUNC_W-1:0]    func,
	input  logic [mipr_pkg::NV_W-1:0]      num_vars,
	output logic                           out_valid,
	input  logic                           out_ready,
	output mipr_pkg::sums_t                out_data
);

	logic             v_s1;
	logic             v_s2;
	logic             rdy_s1;
	logic             rdy_s2;
	mipr_pkg::diff_t  d_s1;
	mipr_pkg::diff_t  d_w;
	mipr_pkg::sums_t  sm_s2;
	mipr_pkg::sums_t  sm_w;
	logic [mipr_pkg::NV_W-1:0] n_eff;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		mipr_pkg::exp_t mi;
		mipr_pkg::exp_t pi;
		logic           act;
		if (num_vars == '0) begin
			n_eff = mipr_pkg::NV_W'(1);
		end else if (num_vars > mipr_pkg::NV_W'(mipr_pkg::MAX_VARS)) begin
			n_eff = mipr_pkg::NV_W'(mipr_pkg::MAX_VARS);
		end else begin
			n_eff = num_vars;
		end
		d_w      = '0;
		d_w.nv   = n_eff;
		d_w.func = func;
		for (int i = 0; i < mipr_pkg::MAX_VARS; i++) begin
			mi  = mon[i*mipr_pkg::EXP_BITS +: mipr_pkg::EXP_BITS];
			pi  = dif[i*mipr_pkg::EXP_BITS +: mipr_pkg::EXP_BITS];
			act = mipr_pkg::NV_W'(i) < n_eff;
			if (act && (mi > pi)) begin
				d_w.zero = 1'b1;
			end else if (act) begin
				d_w.q[i] = pi - mi;
			end
		end
	end

	// Slot i gets the sum of all differences after it; the rank stage needs each.
	always_comb begin
		logic [mipr_pkg::DEG_W-1:0] acc;
		logic [mipr_pkg::DEG_W-1:0] deg_full;
		acc  = '0;
		sm_w = '0;
		for (int i = mipr_pkg::MAX_VARS - 2; i >= 0; i--) begin
			acc = acc + mipr_pkg::DEG_W'(d_s1.q[i+1]);
			sm_w.suf[i] = acc[mipr_pkg::ORD_W-1:0];
		end
		deg_full     = acc + mipr_pkg::DEG_W'(d_s1.q[0]);
		sm_w.zero    = d_s1.zero;
		sm_w.too_high = !d_s1.zero && (deg_full > mipr_pkg::DEG_W'(mipr_pkg::MAX_ORDER));
		sm_w.nv      = d_s1.nv;
		sm_w.func    = d_s1.func;
		sm_w.deg     = deg_full[mipr_pkg::ORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			d_s1 <= d_w;
		end
		if (v_s1 && rdy_s2) begin
			sm_s2 <= sm_w;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = sm_s2;

endmodule

/* rtl/mipr_rank.sv */
// Stage 3: lexicographic rank and binomial table lookups.
`timescale 1ns / 1ps
module mipr_rank (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mipr_pkg::sums_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output mipr_pkg::rank_t out_data
);

	logic            v_s3;
	logic            rdy_s3;
	mipr_pkg::rank_t rk_s3;
	mipr_pkg::rank_t rk_w;

	assign rdy_s3   = !v_s3 || out_ready;
	assign in_ready = rdy_s3;

	// Vectors ahead of q at slot i number C(s + m - 1, m), where s is the
	// degree left after slot i and m the count of later slots.
	always_comb begin
		logic [mipr_pkg::PAS_W-1:0] nv4;
		logic [mipr_pkg::PAS_W-1:0] dg4;
		logic [mipr_pkg::PAS_W-1:0] m;
		logic [mipr_pkg::PAS_W-1:0] row;
		logic [mipr_pkg::PAS_W-1:0] row_c;
		logic [mipr_pkg::BIN_W-1:0] acc;
		nv4   = mipr_pkg::PAS_W'(in_data.nv);
		dg4   = mipr_pkg::PAS_W'(in_data.deg);
		acc   = '0;
		for (int i = 0; i < mipr_pkg::MAX_VARS - 1; i++) begin
			m   = nv4 - mipr_pkg::PAS_W'(i + 1);
			row = mipr_pkg::PAS_W'(in_data.suf[i]) + m - mipr_pkg::PAS_W'(1);
			if (mipr_pkg::PAS_W'(i + 1) < nv4) begin
				acc = acc + mipr_pkg::PASCAL[row][m];
			end
		end
		row_c        = nv4 + dg4 - mipr_pkg::PAS_W'(1);
		rk_w.zero    = in_data.zero;
		rk_w.too_high = in_data.too_high;
		rk_w.func    = in_data.func;
		rk_w.rank    = acc;
		rk_w.cnt     = mipr_pkg::PASCAL[row_c][dg4];
		if (dg4 == '0) begin
			rk_w.pre = '0;
		end else begin
			rk_w.pre = mipr_pkg::PASCAL[row_c][dg4 - mipr_pkg::PAS_W'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s3) begin
			rk_s3 <= rk_w;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = rk_s3;

endmodule

/* rtl/mipr_addr.sv */
// Stages 4 and 5: base offset products and the final address sum.
`timescale 1ns / 1ps
module mipr_addr (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mipr_pkg::NF_W-1:0] num_funcs,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  mipr_pkg::rank_t           in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output mipr_pkg::result_t         out_data
);

	logic              v_s4;
	logic              v_s5;
	logic              rdy_s4;
	logic              rdy_s5;
	mipr_pkg::prod_t   pr_s4;
	mipr_pkg::prod_t   pr_w;
	mipr_pkg::result_t res_s5;
	mipr_pkg::result_t res_w;

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_comb begin
		pr_w.zero     = in_data.zero;
		pr_w.too_high = in_data.too_high;
		pr_w.rank     = in_data.rank;
		pr_w.p_funcs  = mipr_pkg::IDX_W'(num_funcs) * mipr_pkg::IDX_W'(in_data.pre);
		pr_w.p_func   = mipr_pkg::IDX_W'(in_data.func) * mipr_pkg::IDX_W'(in_data.cnt);
	end

	// The address wraps at the index width; it reads zero when it means nothing.
	always_comb begin
		res_w.entry_is_zero   = pr_s4.zero;
		res_w.degree_too_high = pr_s4.too_high;
		if (pr_s4.zero || pr_s4.too_high) begin
			res_w.source_index = '0;
		end else begin
			res_w.source_index = pr_s4.p_funcs + pr_s4.p_func
				+ mipr_pkg::IDX_W'(pr_s4.rank);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) begin
				v_s4 <= in_valid;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s4) begin
			pr_s4 <= pr_w;
		end
		if (v_s4 && rdy_s5) begin
			res_s5 <= res_w;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule

/* rtl/multi_index_partial_rank_core.sv */
// Top level of the multi-index partial rank core: config registers and pipeline.
//
//   Channel   Direction  Handshake                      Contents
//   s_axis    in         s_axis_tvalid / s_axis_tready  exponent vectors and function number
//   m_axis    out        m_axis_tvalid / m_axis_tready  zero flag, source index, degree flag
//   cfg       in         cfg_wr_en (no wait)            num_vars, num_funcs
//
// Five register stages, s1 to s5, lie between an item's transfer in and its result.
// One item per cycle is sustained while the output does not stall; the table lookups
// share stage 3 and the two multiplies share stage 4.
// A stall at the output backs up stage by stage; every stage holds its item.
// Reset clears the stage valid bits and loads num_vars = 4, num_funcs = 1.
`timescale 1ns / 1ps
module multi_index_partial_rank_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [31:0] mon_exponents, [63:32] diff_exponents, [69:64] func, [71:70] zero
	input  logic [mipr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] entry_is_zero, [20:1] source_index, [21] degree_too_high, [23:22] zero
	output logic [mipr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_wr_en,
	input  logic [mipr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mipr_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

	logic [mipr_pkg::NV_W-1:0] num_vars_q;
	logic [mipr_pkg::NF_W-1:0] num_funcs_q;
	logic                      sums_valid;
	logic                      sums_ready;
	mipr_pkg::sums_t           sums;
	logic                      rank_valid;
	logic                      rank_ready;
	mipr_pkg::rank_t           rank;
	mipr_pkg::result_t         result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q  <= mipr_pkg::NV_W'(4);
			num_funcs_q <= mipr_pkg::NF_W'(1);
		end else if (cfg_wr_en) begin
			case (mipr_pkg::cfg_reg_t'(cfg_index))
				mipr_pkg::CFG_NUM_VARS: begin
					num_vars_q <= cfg_wr_data[mipr_pkg::NV_W-1:0];
				end
				mipr_pkg::CFG_NUM_FUNCS: begin
					num_funcs_q <= cfg_wr_data[mipr_pkg::NF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	mipr_diff u_diff (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.mon       (s_axis_tdata[mipr_pkg::EXP_VEC_W-1:0]),
		.dif       (s_axis_tdata[2*mipr_pkg::EXP_VEC_W-1:mipr_pkg::EXP_VEC_W]),
		.func      (s_axis_tdata[2*mipr_pkg::EXP_VEC_W +: mipr_pkg::FUNC_W]),
		.num_vars  (num_vars_q),
		.out_valid (sums_valid),
		.out_ready (sums_ready),
		.out_data  (sums)
	);

	mipr_rank u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sums_valid),
		.in_ready  (sums_ready),
		.in_data   (sums),
		.out_valid (rank_valid),
		.out_ready (rank_ready),
		.out_data  (rank)
	);

	mipr_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_funcs (num_funcs_q),
		.in_valid  (rank_valid),
		.in_ready  (rank_ready),
		.in_data   (rank),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (result)
	);

	assign m_axis_tdata = {2'b00, result.degree_too_high, result.source_index,
		result.entry_is_zero};

endmodule

/* sim/mipr_rank_checker.sv */
// Checker that predicts each entry address of the multi-index rank core and compares results.
`timescale 1ns / 1ps
module mipr_rank_checker
	import mipr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
	output int                     fail_count,
	output int                     pending
);

	logic [NV_W-1:0] vars_shadow;
	logic [NF_W-1:0] funcs_shadow;
	result_t         expected_entries[$];

	function automatic longint choose(input int a, input int b);
		longint r;
		int     i;
		r = 1;
		if (b < 0 || b > a) begin
			return 0;
		end
		for (i = 1; i <= b; i++) begin
			r = r * (a - b + i) / i;
		end
		return r;
	endfunction

	function automatic result_t predict_entry(
		input logic [EXP_VEC_W-1:0] mon,
		input logic [EXP_VEC_W-1:0] dif,
		input logic [FUNC_W-1:0]    fn,
		input logic [NV_W-1:0]      nv,
		input logic [NF_W-1:0]      nf
	);
		result_t r;
		int      n;
		int      deg;
		int      i;
		int      a;
		int      rem;
		int      rest;
		int      mi;
		int      pi;
		int      q[MAX_VARS];
		longint  addr;
		r = '0;
		n = int'(nv);
		if (n < 1) begin
			n = 1;
		end
		if (n > MAX_VARS) begin
			n = MAX_VARS;
		end
		deg = 0;
		for (i = 0; i < MAX_VARS; i++) begin
			q[i] = 0;
		end
		for (i = 0; i < n; i++) begin
			mi = int'(mon[i*EXP_BITS +: EXP_BITS]);
			pi = int'(dif[i*EXP_BITS +: EXP_BITS]);
			if (mi > pi) begin
				r.entry_is_zero = 1'b1;
			end else begin
				q[i] = pi - mi;
				deg += q[i];
			end
		end
		if (r.entry_is_zero) begin
			return r;
		end
		if (deg > MAX_ORDER) begin
			r.degree_too_high = 1'b1;
			return r;
		end
		// Block offset of all lower degrees, then the function's block within degree deg.
		addr = 0;
		for (i = 0; i < deg; i++) begin
			addr += longint'(nf) * choose(n + i - 1, i);
		end
		addr += longint'(fn) * choose(n + deg - 1, deg);
		// Every larger leading exponent at slot i contributes all completions of the tail.
		rem = deg;
		for (i = 0; i + 1 < n; i++) begin
			rest = n - i - 1;
			for (a = q[i] + 1; a <= rem; a++) begin
				addr += choose(rem - a + rest - 1, rest - 1);
			end
			rem -= q[i];
		end
		r.source_index = addr[IDX_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			vars_shadow = NV_W'(4);
			funcs_shadow = NF_W'(1);
			expected_entries.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.entry_is_zero = m_axis_tdata[0];
				got.source_index = m_axis_tdata[IDX_W:1];
				got.degree_too_high = m_axis_tdata[IDX_W+1];
				if (expected_entries.size() == 0) begin
					if (fail_count < 10) begin
						$display("[%0t] result transfer with nothing expected:",
							$realtime);
						$display("    zero=%0b idx=%0d high=%0b", got.entry_is_zero,
							got.source_index, got.degree_too_high);
					end
					fail_count++;
				end else begin
					want = expected_entries.pop_front();
					if (got.entry_is_zero !== want.entry_is_zero ||
							got.source_index !== want.source_index ||
							got.degree_too_high !== want.degree_too_high) begin
						if (fail_count < 10) begin
							$display("[%0t] mismatch:", $realtime);
							$display("    expected zero=%0b idx=%0d high=%0b",
								want.entry_is_zero, want.source_index,
								want.degree_too_high);
							$display("    got      zero=%0b idx=%0d high=%0b",
								got.entry_is_zero, got.source_index,
								got.degree_too_high);
						end
						fail_count++;
					end
				end
			end
			// The input uses the register values from before any write at this same edge.
			if (s_axis_tvalid && s_axis_tready) begin
				expected_entries.push_back(predict_entry(s_axis_tdata[EXP_VEC_W-1:0],
					s_axis_tdata[2*EXP_VEC_W-1:EXP_VEC_W],
					s_axis_tdata[2*EXP_VEC_W +: FUNC_W], vars_shadow, funcs_shadow));
			end
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					CFG_NUM_VARS: begin
						vars_shadow = cfg_wr_data[NV_W-1:0];
					end
					CFG_NUM_FUNCS: begin
						funcs_shadow = cfg_wr_data[NF_W-1:0];
					end
					default: begin
					end
				endcase
			end
			pending = expected_entries.size();
		end
	end

endmodule

/* sim/tb.sv */
// Testbench top: clock, reset, stimulus and verdict for the multi-index rank core.
`timescale 1ns / 1ps
module tb;
	import mipr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 100;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int eff_vars = 4;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	multi_index_partial_rank_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data)
	);

	mipr_rank_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Writes num_vars, then num_funcs; called only while the core is idle.
	task automatic load_config(input logic [CFG_DATA_W-1:0] nv, input logic [CFG_DATA_W-1:0] nf);
		int v;
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_NUM_VARS;
		cfg_wr_data <= nv;
		@(negedge clk);
		cfg_index <= CFG_NUM_FUNCS;
		cfg_wr_data <= nf;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		v = int'(nv[NV_W-1:0]);
		if (v < 1) begin
			v = 1;
		end
		if (v > MAX_VARS) begin
			v = MAX_VARS;
		end
		eff_vars = v;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic send_item(input logic [EXP_VEC_W-1:0] mon, input logic [EXP_VEC_W-1:0] dif,
		input logic [FUNC_W-1:0] fn);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, fn, dif, mon};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Mostly valid difference vectors of rankable degree; the rest overflow the degree,
	// break one active slot or are plain noise.
	task automatic gen_item(output logic [EXP_VEC_W-1:0] mon, output logic [EXP_VEC_W-1:0] dif,
		output logic [FUNC_W-1:0] fn);
		int kind;
		int deg;
		int placed;
		int slot_i;
		int i;
		int lo;
		int top;
		int q[MAX_VARS];
		kind = $urandom_range(0, 99);
		fn = FUNC_W'($urandom_range(0, 63));
		mon = $urandom;
		dif = $urandom;
		if (kind >= 90) begin
			return;
		end
		for (i = 0; i < MAX_VARS; i++) begin
			q[i] = 0;
		end
		if (kind >= 70 && kind < 80) begin
			top = 15 * eff_vars;
			deg = $urandom_range(MAX_ORDER + 1, (top < 24) ? top : 24);
		end else if ($urandom_range(0, 4) == 0) begin
			deg = MAX_ORDER;
		end else begin
			deg = $urandom_range(0, MAX_ORDER);
		end
		placed = 0;
		while (placed < deg) begin
			slot_i = $urandom_range(0, eff_vars - 1);
			if (q[slot_i] < 15) begin
				q[slot_i]++;
				placed++;
			end
		end
		for (i = 0; i < eff_vars; i++) begin
			lo = $urandom_range(0, 15 - q[i]);
			mon[i*EXP_BITS +: EXP_BITS] = EXP_BITS'(lo);
			dif[i*EXP_BITS +: EXP_BITS] = EXP_BITS'(lo + q[i]);
		end
		if (kind >= 80) begin
			slot_i = $urandom_range(0, eff_vars - 1);
			lo = $urandom_range(1, 15);
			mon[slot_i*EXP_BITS +: EXP_BITS] = EXP_BITS'(lo);
			dif[slot_i*EXP_BITS +: EXP_BITS] = EXP_BITS'($urandom_range(0, lo - 1));
		end
	endtask

	initial begin : sink
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				rx_burst = !rx_burst;
			end
			stall = rx_burst ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [EXP_VEC_W-1:0] mon;
		logic [EXP_VEC_W-1:0] dif;
		logic [FUNC_W-1:0]    fn;
		int                   ph;
		int                   k;
		logic [CFG_DATA_W-1:0] vars_plan[PHASES];
		logic [CFG_DATA_W-1:0] funcs_plan[PHASES];
		vars_plan = '{7'd1, 7'd8, 7'd2, 7'd0, 7'd15, 7'd3, 7'd5, 7'h48};
		funcs_plan = '{7'd1, 7'd64, 7'd3, 7'd0, 7'd127, 7'd17, 7'd64, 7'd1};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: four variables, one function.
		send_item(32'h0000_0000, 32'h0000_0000, 6'd0);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
		send_item(32'h0000_0000, 32'h0000_0007, 6'd0);
		send_item(32'h0000_0000, 32'h0000_7000, 6'd1);
		send_item(32'h0000_0000, 32'h0000_0008, 6'd2);
		send_item(32'h0000_0001, 32'h0000_0000, 6'd3);
		// Slots above the variable count are ignored, even when they would give a zero entry; an active slot is not.
		send_item(32'hF000_0000, 32'h0000_0000, 6'd4);
		send_item(32'h0000_0001, 32'h0000_00F0, 6'd5);
		settle();

		load_config(7'd8, 7'd64);
		send_item(32'h0000_0000, 32'h1111_1111, 6'd0);
		send_item(32'h0000_0000, 32'h7000_0000, 6'd63);
		send_item(32'h0000_0000, 32'h0001_0213, 6'd5);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
		send_item(32'h8000_0000, 32'h7FFF_FFFF, 6'd7);
		settle();

		// A zero variable count acts as one; zero functions still use the formula.
		load_config(7'd0, 7'd0);
		send_item(32'h0000_0000, 32'h0000_0007, 6'd63);
		send_item(32'h0000_0000, 32'hFFFF_FFF3, 6'd10);
		settle();

		load_config(7'h7F, 7'd127);
		send_item(32'h0000_0000, 32'h0000_0007, 6'd63);
		send_item(32'h0000_0000, 32'h0100_0060, 6'd33);
		send_item(32'h0000_0000, 32'h0000_0007, 6'd0);
		settle();

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph >= 5 && $urandom_range(0, 1) == 1) begin
				load_config(CFG_DATA_W'($urandom_range(0, 127)),
					CFG_DATA_W'($urandom_range(0, 127)));
			end else begin
				load_config(vars_plan[ph], funcs_plan[ph]);
			end
			tx_burst = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// Partway through one phase the sender holds off until the pipe is empty.
				if (ph == 3 && k == PHASE_ITEMS / 2) begin
					settle();
				end
				if ($urandom_range(0, 49) == 0) begin
					tx_burst = !tx_burst;
				end
				gen_item(mon, dif, fn);
				send_item(mon, dif, fn);
			end
			settle();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/mipr_pkg.sv
rtl/mipr_diff.sv
rtl/mipr_rank.sv
rtl/mipr_addr.sv
rtl/multi_index_partial_rank_core.sv
sim/mipr_rank_checker.sv
sim/tb.sv
